@@ hdl/fpr_pkg.sv @@
package fpr_pkg;

  localparam int NUM_FRAMES = 32;
  localparam int NUM_PAGES  = 64;

  localparam int PAGE_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int FRAME_W = 5;
  localparam int CFG_W   = 7;
  localparam int CNT_W   = $clog2(NUM_PAGES + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // latch the accepted word and clear the result
    logic scan;          // one step of the victim search
    logic fault_commit;  // evict, map the faulting page, advance the pointer
    logic wr_read;       // read the frame of the written page
    logic wr_commit;     // mark the page dirty and report its frame
    logic out_load;      // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;      // page of the offered word is below the page limit
    logic act_write;     // offered word is a write access
    logic scan_done;     // search hit the owner or ran past the last page
    logic out_free;      // output register can take a result this cycle
  } status_t;

endpackage

@@ hdl/fpr_ctrl.sv @@
module fpr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fpr_pkg::status_t st,
  output fpr_pkg::cmd_t    cmd
);
  import fpr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_WREAD  = 3'd3;
  localparam logic [2:0] S_WDONE  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!st.in_range) begin
            state_next = S_FINISH;
          end else if (st.act_write) begin
            state_next = S_WREAD;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.fault_commit = 1'b1;
        state_next       = S_FINISH;
      end
      S_WREAD: begin
        cmd.wr_read = 1'b1;
        state_next  = S_WDONE;
      end
      S_WDONE: begin
        cmd.wr_commit = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/fpr_dp.sv @@
module fpr_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fpr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          action,
  input  logic [fpr_pkg::PAGE_W-1:0]    page,
  input  fpr_pkg::cmd_t                 cmd,
  output fpr_pkg::status_t              st,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fpr_pkg::FRAME_W-1:0]   frame,
  output logic                          evicted,
  output logic [fpr_pkg::PAGE_W-1:0]    evicted_page,
  output logic                          write_back
);
  import fpr_pkg::*;

  logic [CFG_W-1:0]     pages_in_use;
  logic [NUM_PAGES-1:0] page_valid;
  logic [NUM_PAGES-1:0] page_dirty;
  logic [FRAME_W-1:0]   next_frame;
  logic [FRAME_W-1:0]   page_frame [NUM_PAGES];
  logic [FRAME_W-1:0]   rdata;
  logic [PAGE_W-1:0]    raddr;

  logic [PAGE_W-1:0]    pg_q;
  logic [CNT_W-1:0]     limit_q;
  logic [CNT_W-1:0]     scan_idx;
  logic [PAGE_W-1:0]    chk_idx;
  logic                 chk_vld;
  logic                 hit;
  logic [PAGE_W-1:0]    victim;

  logic [FRAME_W-1:0]   res_frame;
  logic                 res_evicted;
  logic [PAGE_W-1:0]    res_evicted_page;
  logic                 res_write_back;

  logic [CNT_W-1:0]     eff_limit;
  logic                 scan_more;
  logic                 hit_now;
  logic [NUM_PAGES-1:0] valid_clr;
  logic [NUM_PAGES-1:0] valid_set;

  // Register values above the table size act as the table size.
  assign eff_limit = (CNT_W'(pages_in_use) > CNT_W'(NUM_PAGES)) ?
                     CNT_W'(NUM_PAGES) : CNT_W'(pages_in_use);

  assign scan_more = (scan_idx < limit_q);
  assign hit_now   = chk_vld && page_valid[chk_idx] && (rdata == next_frame);
  assign raddr     = cmd.wr_read ? pg_q : scan_idx[PAGE_W-1:0];

  assign valid_clr = hit ? (NUM_PAGES'(1) << victim) : '0;
  assign valid_set = NUM_PAGES'(1) << pg_q;

  assign st.in_range  = (CNT_W'(page) < eff_limit);
  assign st.act_write = action;
  assign st.scan_done = hit_now || (!scan_more && !chk_vld);
  assign st.out_free  = !out_valid || out_ready;

  // Frame table: one write port for the fault commit, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.fault_commit) begin
      page_frame[pg_q] <= next_frame;
    end
    rdata <= page_frame[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= CFG_W'(NUM_PAGES);
      page_valid   <= '0;
      page_dirty   <= '0;
      next_frame   <= '0;
      chk_vld      <= 1'b0;
      hit          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pages_in_use <= cfg_wr_data;
      end

      chk_vld <= cmd.scan && scan_more;

      if (cmd.load) begin
        hit <= 1'b0;
      end else if (cmd.scan && hit_now) begin
        hit <= 1'b1;
      end

      // The victim is cleared before the faulting page is set, so a page which
      // evicts itself stays valid.
      if (cmd.fault_commit) begin
        page_valid       <= (page_valid & ~valid_clr) | valid_set;
        page_dirty[pg_q] <= 1'b0;
        if (next_frame == FRAME_W'(NUM_FRAMES - 1)) begin
          next_frame <= '0;
        end else begin
          next_frame <= next_frame + FRAME_W'(1);
        end
      end

      if (cmd.wr_commit && page_valid[pg_q]) begin
        page_dirty[pg_q] <= 1'b1;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pg_q             <= page;
      limit_q          <= eff_limit;
      scan_idx         <= '0;
      res_frame        <= '0;
      res_evicted      <= 1'b0;
      res_evicted_page <= '0;
      res_write_back   <= 1'b0;
    end

    if (cmd.scan) begin
      chk_idx <= scan_idx[PAGE_W-1:0];
      if (scan_more) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (hit_now) begin
        victim <= chk_idx;
      end
    end

    if (cmd.fault_commit) begin
      res_frame        <= next_frame;
      res_evicted      <= hit;
      res_evicted_page <= hit ? victim : '0;
      res_write_back   <= hit && page_dirty[victim];
    end

    if (cmd.wr_commit && page_valid[pg_q]) begin
      res_frame <= rdata;
    end

    if (cmd.out_load) begin
      frame        <= res_frame;
      evicted      <= res_evicted;
      evicted_page <= res_evicted_page;
      write_back   <= res_write_back;
    end
  end

endmodule

@@ hdl/fifo_page_replacement_top.sv @@
// FIFO page replacement unit: page table with valid, frame and dirty per page.
// An accepted word is processed in turn: a fault searches the frame table up to the page limit
// (64 at most), one read per cycle, then updates; a write access reads and commits the
// frame, and an out-of-range page goes straight to the output. One word is in work at a
// time, so a new word is taken only once the result of the last one is staged.
// Reset (synchronous, active high) clears valid and dirty bits, pointer and output.
module fifo_page_replacement_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fpr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [fpr_pkg::PAGE_W-1:0]    page,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fpr_pkg::FRAME_W-1:0]   frame,
  output logic                          evicted,
  output logic [fpr_pkg::PAGE_W-1:0]    evicted_page,
  output logic                          write_back
);
  import fpr_pkg::*;

  // The controller sequences one word at a time: accept, search or read, commit,
  // and hand the result to the output register. The datapath holds the page
  // table, the frame memory, the FIFO pointer and the result registers.
  // Reset also sets pages_in_use to the table size.
  cmd_t    cmd;
  status_t st;

  fpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The output register is separate from the result registers, so a new word
  // can be accepted and processed while the previous result waits to be taken.
  fpr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .action       (action),
    .page         (page),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame        (frame),
    .evicted      (evicted),
    .evicted_page (evicted_page),
    .write_back   (write_back)
  );

`ifndef SYNTH
  // Once a word is taken the block is busy until its result is staged.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // A result is never loaded over one that has not yet been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_valid || out_ready)
    else $error("output register overwritten while full");

  // Without an eviction there is no evicted page and no write-back.
  a_no_evict_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_page == '0 && !write_back)
    else $error("eviction fields set without an eviction");
`endif

endmodule
